FILE: hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and helper functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned TOTAL_W = 61;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   // controller to datapath commands
   typedef struct packed {
      logic       load_byte;   // write one byte into the block window
      logic       pad_mark;    // write the 0x80 marker at the current fill
      logic       pad_write;   // write a zero padding byte at the current fill
      logic       len_write;   // write one length byte
      logic [2:0] len_idx;     // length byte index 0..7
      logic       fill_clr;    // restart the fill counter
      logic       rnd_start;   // copy hash into working vars, round 0
      logic       rnd_step;    // run one round
      logic       hash_add;    // fold working vars into hash
      logic       hash_init;   // reload initial hash, clear length
      logic       out_shift;   // rotate output word order
   } sha_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [6:0] fill;
      logic       round_last;
   } sha_stat_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
         32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
         32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
         32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
         32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
         32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[i];
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] h [8];
      h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
            32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
      return h[i];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

FILE: hdl/sha256_message_hasher_top.sv
// intake: a byte is taken while idle; every 64th byte starts a compression
// (one round per cycle in the shared round unit), during which no byte is taken
// message end: padding, a compression per padded block, then 8 words
// flow: one item at a time; after message end the next item waits for the digest
// reset: synchronous, loads the initial hash and clears fill and byte counts
// ----------------------------------------------------------------------------
// sha256_message_hasher_top
// Byte-stream SHA-256 hasher emitting eight digest words per message.
// ----------------------------------------------------------------------------
module sha256_message_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_digest_last
);
   import sha256_pkg::*;

   sha_cmd_type  cmd;
   sha_stat_type stat;

   sha256_control u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .byte_present(req_byte_present), .message_end(req_message_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_digest_last(rsp_digest_last),
      .stat(stat), .cmd(cmd)
   );

   sha256_datapath u_dp (
      .clock(clock), .reset(reset),
      .cmd(cmd), .byte_in(req_data_byte),
      .stat(stat), .word_out(rsp_digest_word)
   );

endmodule

FILE: hdl/sha256_datapath.sv
// ----------------------------------------------------------------------------
// sha256_datapath
// Block window as a 16-word schedule shift register, round unit, hash
// registers, fill counter and byte total.
// ----------------------------------------------------------------------------
module sha256_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  sha256_pkg::sha_cmd_type  cmd,
   input  logic [7:0]               byte_in,
   output sha256_pkg::sha_stat_type stat,
   output logic [31:0]              word_out
);
   import sha256_pkg::*;

   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] h_ff [8];
   logic [6:0]  fill_ff;
   logic [5:0]  rnd_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [63:0] bits;
   logic [7:0]  wr_byte;
   logic        wr_en;
   logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2;

   assign bits = {total_ff, 3'b000};

   // byte to write into the window
   always_comb begin
      wr_en   = cmd.load_byte | cmd.pad_mark | cmd.pad_write | cmd.len_write;
      wr_byte = 8'h00;
      if (cmd.load_byte) wr_byte = byte_in;
      else if (cmd.pad_mark) wr_byte = PAD_BYTE;
      else if (cmd.len_write) wr_byte = bits[6'(56 - 8*int'(cmd.len_idx)) +: 8];
   end

   // schedule and round logic
   always_comb begin
      s0    = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1    = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      big1  = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1    = v_ff[7] + big1 + ch + round_k(rnd_ff) + w_ff[0];
      big0  = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2    = big0 + maj;
   end

   // window: bytes enter at the right, word 0 leaves first
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= {w_ff[i][23:0], w_ff[i+1][31:24]};
         w_ff[15] <= {w_ff[15][23:0], wr_byte};
      end else if (cmd.rnd_step) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
   end

   // working variables and hash
   always_ff @(posedge clock) begin
      if (cmd.rnd_start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (cmd.rnd_step) begin
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.hash_init) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
      end else if (cmd.hash_add) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end else if (cmd.out_shift) begin
         for (int i = 0; i < 7; i++) h_ff[i] <= h_ff[i+1];
         h_ff[7] <= h_ff[0];
      end
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         rnd_ff   <= '0;
         total_ff <= '0;
      end else begin
         if (cmd.fill_clr)   fill_ff <= '0;
         else if (wr_en)     fill_ff <= fill_ff + 7'd1;
         if (cmd.rnd_start)  rnd_ff <= '0;
         else if (cmd.rnd_step) rnd_ff <= rnd_ff + 6'd1;
         if (cmd.hash_init)  total_ff <= '0;
         else if (cmd.load_byte) total_ff <= total_ff + TOTAL_W'(1);
      end
   end

   assign stat.fill       = fill_ff;
   assign stat.round_last = (rnd_ff == 6'd63);
   assign word_out        = h_ff[0];

endmodule

FILE: hdl/sha256_control.sv
// ----------------------------------------------------------------------------
// sha256_control
// Sequencer: byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha256_control (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     byte_present,
   input  logic                     message_end,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_digest_last,
   input  sha256_pkg::sha_stat_type stat,
   output sha256_pkg::sha_cmd_type  cmd
);
   import sha256_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_PAD80 = 8'b0000_0010,
      ST_ZERO  = 8'b0000_0100,
      ST_LEN   = 8'b0000_1000,
      ST_START = 8'b0001_0000,
      ST_ROUND = 8'b0010_0000,
      ST_ADD   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;     // message closing in progress
   logic      pend_ff, pend_in;   // 0x80 marker still to write
   logic      lenph_ff, lenph_in; // current block carries the length
   logic [2:0] cnt_ff, cnt_in;
   logic      acc;

   assign acc       = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_digest_last = (cnt_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      pend_in  = pend_ff;
      lenph_in = lenph_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.len_idx = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               cmd.load_byte = byte_present;
               if (byte_present && stat.fill == 7'd63) begin
                  fin_in   = message_end;
                  pend_in  = message_end;
                  lenph_in = 1'b0;
                  state_in = ST_START;
               end else if (message_end) begin
                  fin_in   = 1'b1;
                  state_in = ST_PAD80;
               end
            end
         end
         ST_PAD80: begin
            // 0x80 marker at the current fill
            cmd.pad_mark = 1'b1;
            pend_in  = 1'b0;
            state_in = ST_ZERO;
         end
         ST_ZERO: begin
            if (pend_ff) begin
               // block after a full-block compress during close: start 0x80
               state_in = ST_PAD80;
            end else if (stat.fill == 7'd56) begin
               cnt_in   = 3'd0;
               state_in = ST_LEN;
            end else if (stat.fill == 7'd64) begin
               // no room for the length: compress, then pad another block
               cmd.fill_clr = 1'b1;
               lenph_in = 1'b0;
               state_in = ST_START;
            end else begin
               cmd.pad_write = 1'b1;
            end
         end
         ST_LEN: begin
            cmd.len_write = 1'b1;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               lenph_in = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.fill_clr  = 1'b1;
            cmd.rnd_start = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.rnd_step = 1'b1;
            if (stat.round_last) state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.hash_add = 1'b1;
            cnt_in = 3'd0;
            if (lenph_ff)    state_in = ST_OUT;
            else if (fin_ff) state_in = ST_ZERO;
            else             state_in = ST_IDLE;
            if (!lenph_ff && !fin_ff) lenph_in = 1'b0;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               cmd.out_shift = 1'b1;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  cmd.out_shift = 1'b0;
                  cmd.hash_init = 1'b1;
                  lenph_in = 1'b0;
                  fin_in   = 1'b0;
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fin_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         lenph_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         pend_ff  <= pend_in;
         lenph_ff <= lenph_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: test/sha256_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches the byte and digest channels of the SHA-256 hasher, keeps its own
// SHA-256 state per message and compares every digest word in order.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_message_end,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_digest_word,
   input  logic        rsp_digest_last,
   output int          fail_count,
   output int          words_pending
);

   localparam logic [31:0] RK [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
   localparam logic [31:0] IV [8] = '{
      32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
      32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } digest_beat_type;

   logic [31:0]     chain [8];
   logic [7:0]      blk [64];
   logic [60:0]     msg_len;
   int              fill;
   digest_beat_type digest_q[$];

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one 64-round compression of blk into chain
   task automatic compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, e, a;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      v = chain;
      for (int i = 0; i < 64; i++) begin
         e = v[4];
         a = v[0];
         t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
            + RK[i] + w[i];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         chain[i] = chain[i] + v[i];
   endtask

   // absorb one item, queue the digest on message end
   task automatic absorb_item(input logic [7:0] b, input logic present, input logic fin);
      logic [63:0] bits;
      if (present) begin
         blk[fill] = b;
         fill++;
         msg_len = msg_len + 61'd1;
         if (fill == 64) begin
            compress();
            fill = 0;
         end
      end
      if (fin) begin
         blk[fill] = 8'h80;
         fill++;
         if (fill > 56) begin
            while (fill < 64) begin
               blk[fill] = 8'h00;
               fill++;
            end
            compress();
            fill = 0;
         end
         while (fill < 56) begin
            blk[fill] = 8'h00;
            fill++;
         end
         bits = {msg_len, 3'b000};
         for (int j = 0; j < 8; j++)
            blk[56+j] = bits[63-8*j -: 8];
         compress();
         for (int j = 0; j < 8; j++)
            digest_q.push_back('{word: chain[j], last: (j == 7)});
         chain = IV;
         msg_len = '0;
         fill = 0;
      end
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: %s got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      chain = IV;
      msg_len = '0;
      fill = 0;
   end

   assign words_pending = digest_q.size();

   // sample both channels at the rising edge
   always @(posedge clock) begin
      digest_beat_type exp_beat;
      if (reset) begin
         chain = IV;
         msg_len = '0;
         fill = 0;
      end else begin
         if (req_valid && req_ready)
            absorb_item(req_data_byte, req_byte_present, req_message_end);
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               report("unexpected digest word", rsp_digest_word, 32'h0);
            end else begin
               exp_beat = digest_q.pop_front();
               if (rsp_digest_word !== exp_beat.word)
                  report("digest_word", rsp_digest_word, exp_beat.word);
               if (rsp_digest_last !== exp_beat.last)
                  report("digest_last", {31'b0, rsp_digest_last}, {31'b0, exp_beat.last});
            end
         end
      end
   end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams directed and random messages into the SHA-256 hasher with random
// gaps and back-pressure; the checker predicts and compares each digest word.
// ----------------------------------------------------------------------------
module tb;

   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_byte_present = 1'b0;
   logic        req_message_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic        rsp_digest_last;
   int          fail_count;
   int          words_pending;
   int          idle_cycles;
   int          items_sent;
   bit          rsp_hold_off;

   always #4 clock = ~clock;

   sha256_message_hasher_top DUT (.*);

   sha256_digest_checker u_checker (.*);

   // send one item after a random gap; valid stays up into a gap-free next item
   task automatic send_item(input logic [7:0] b, input logic present, input logic fin,
                            input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_byte_present <= present;
      req_message_end <= fin;
      // ready is stable at the falling edge; the next rising edge accepts
      while (!req_ready) @(negedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_message(input int len, input bit with_holes);
      for (int i = 0; i < len; i++) begin
         if (with_holes && $urandom_range(0, 9) == 0)
            send_item($urandom, 1'b0, 1'b0);
         send_item($urandom, 1'b1, (i == len - 1));
      end
      if (len == 0) send_item($urandom, 1'b0, 1'b1);
   endtask

   task automatic drain_digests();
      req_valid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
   endtask

   // random receiver stalls, with quiet stretches of always-ready
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         @(negedge clock);
         stall = rsp_hold_off ? 0 : $urandom_range(0, 12);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      int len;
      idle_cycles = 0;
      items_sent = 0;
      rsp_hold_off = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty message, one byte extremes, padding boundaries
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hff, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      drain_digests();
      rsp_hold_off = 1;
      send_message(55, 0);
      send_message(56, 0);
      drain_digests();
      rsp_hold_off = 0;
      send_message(63, 0);
      send_message(64, 0);
      send_message(65, 1);
      // sender pauses until every digest word has come back
      drain_digests();

      // random messages, mostly short, a few spanning blocks
      while (items_sent < 390) begin
         case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = $urandom_range(54, 66);
            2:       len = $urandom_range(100, 140);
            default: len = $urandom_range(1, 20);
         endcase
         if (items_sent + len > 410) len = 410 - items_sent;
         send_message(len, 1);
         if ($urandom_range(0, 7) == 0) drain_digests();
      end
      drain_digests();
      repeat (200) @(posedge clock);

      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: sha256_message_hasher_top.f
hdl/sha256_pkg.sv
hdl/sha256_datapath.sv
hdl/sha256_control.sv
hdl/sha256_message_hasher_top.sv
test/sha256_digest_checker.sv
test/tb.sv
